>>> hdl/fhp_pkg.sv
// ----------------------------------------------------------------------------
// fhp_pkg: shared types and constants of the L2-L4 flow header parser
// Holds the field types of the input and result words, the status codes and
// the protocol numbers that the parser recognizes.
// ----------------------------------------------------------------------------
package fhp_pkg;

  // Field types of the input and result words
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  status_t;
  typedef logic [63:0] addr_t;
  typedef logic [15:0] half_t;

  // Result word as held in the output register
  typedef struct packed {
    status_t status;
    logic    is_ipv6;
    byte_t   ip_proto;
    addr_t   src_addr_high;
    addr_t   src_addr_low;
    addr_t   dst_addr_high;
    addr_t   dst_addr_low;
    half_t   src_port;
    half_t   dst_port;
    half_t   payload_len;
  } result_t;

  // Status codes
  localparam status_t ST_OK            = 3'd0;
  localparam status_t ST_NOT_IP        = 3'd1;
  localparam status_t ST_TRUNC         = 3'd2;
  localparam status_t ST_BAD_NH        = 3'd3;
  localparam status_t ST_BAD_TRANSPORT = 3'd4;
  localparam status_t ST_TOO_MANY_EXT  = 3'd5;
  localparam status_t ST_OVERSIZE      = 3'd6;

  // Ethertypes
  localparam half_t ETH_IPV4 = 16'h0800;
  localparam half_t ETH_IPV6 = 16'h86DD;

  // IP protocol / next header numbers
  localparam byte_t NH_HOP_BY_HOP = 8'd0;
  localparam byte_t NH_TCP        = 8'd6;
  localparam byte_t NH_UDP        = 8'd17;
  localparam byte_t NH_ROUTING    = 8'd43;
  localparam byte_t NH_FRAGMENT   = 8'd44;
  localparam byte_t NH_DEST_OPT   = 8'd60;

  // Header lengths in bytes
  localparam logic [6:0] TCP_MIN_HLEN = 7'd20;
  localparam logic [6:0] UDP_HLEN     = 7'd8;

endpackage

>>> hdl/fhp_in_if.sv
// ----------------------------------------------------------------------------
// fhp_in_if: frame byte channel
// Carries one captured frame byte per word, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface fhp_in_if;
  logic          valid;
  logic          ready;
  fhp_pkg::byte_t data_byte;
  logic          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/fhp_out_if.sv
// ----------------------------------------------------------------------------
// fhp_out_if: parse result channel
// Carries one result word per frame: status, IP version, protocol,
// addresses, ports and payload length.
// ----------------------------------------------------------------------------
interface fhp_out_if;
  logic             valid;
  logic             ready;
  fhp_pkg::status_t status;
  logic             is_ipv6;
  fhp_pkg::byte_t   ip_proto;
  fhp_pkg::addr_t   src_addr_high;
  fhp_pkg::addr_t   src_addr_low;
  fhp_pkg::addr_t   dst_addr_high;
  fhp_pkg::addr_t   dst_addr_low;
  fhp_pkg::half_t   src_port;
  fhp_pkg::half_t   dst_port;
  fhp_pkg::half_t   payload_len;

  modport source (
    output valid, output status, output is_ipv6, output ip_proto,
    output src_addr_high, output src_addr_low, output dst_addr_high,
    output dst_addr_low, output src_port, output dst_port, output payload_len,
    input ready
  );
  modport sink (
    input valid, input status, input is_ipv6, input ip_proto,
    input src_addr_high, input src_addr_low, input dst_addr_high,
    input dst_addr_low, input src_port, input dst_port, input payload_len,
    output ready
  );
endinterface

>>> hdl/l2_l4_flow_header_parser_top.sv
// ----------------------------------------------------------------------------
// l2_l4_flow_header_parser_top: Ethernet / IPv4 / IPv6 / TCP / UDP parser
// Takes a frame one byte per word and gives one result word at its last byte.
// Result path: an accepted last byte passes the input register, then the
// result register, where its result word becomes valid.
// Throughput: one byte per cycle; a last byte waits in the input register
// only while the result register is still full and stalled.
// Reset: asynchronous; clears the parse state and both registers' valid flags.
// ----------------------------------------------------------------------------
module l2_l4_flow_header_parser_top #(
  parameter int MAX_EXT_HEADERS = 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  fhp_in_if.sink        in_i,
  fhp_out_if.source     out_o
);

  typedef enum logic [2:0] {
    PH_ETH,
    PH_IPV4,
    PH_IPV6,
    PH_EXT,
    PH_TRANSPORT,
    PH_ERROR
  } phase_e;

  localparam logic [3:0] MaxExt = 4'(MAX_EXT_HEADERS);

  // Input register
  logic           in_valid_q;
  fhp_pkg::byte_t in_byte_q;
  logic           in_last_q;
  logic           process;
  logic           out_free;

  // Parse state
  phase_e           phase_q, phase_d;
  logic [15:0]      offset_q, offset_d;
  logic [15:0]      ether_q, ether_d;
  fhp_pkg::byte_t   nh_q, nh_d;
  logic [15:0]      seo_q, seo_d;
  logic [15:0]      ts_q, ts_d;
  logic [3:0]       ext_q, ext_d;
  fhp_pkg::addr_t   src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  fhp_pkg::addr_t   dst_hi_q, dst_hi_d, dst_lo_q, dst_lo_d;
  logic [31:0]      ports_q, ports_d;
  logic [6:0]       thl_q, thl_d;
  fhp_pkg::status_t err_q, err_d;
  logic             frag_q, frag_d;
  logic [15:0]      udp_q, udp_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  fhp_pkg::result_t res_q, res_d;

  assign out_free = !out_valid_q || out_o.ready;
  assign process  = in_valid_q && (!in_last_q || out_free);
  assign in_i.ready = !in_valid_q || process;

  // Capture the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Advance the parse state by one byte and form the result at the last byte
  always_comb begin
    logic [15:0]      off;
    logic [15:0]      rel;
    fhp_pkg::byte_t   b;
    logic [7:0]       hl;
    logic             enter;
    fhp_pkg::byte_t   en_type;
    logic [15:0]      en_start;
    logic [16:0]      sum;
    logic [16:0]      caplen;
    logic [16:0]      after;
    fhp_pkg::status_t st;

    phase_d  = phase_q;
    offset_d = offset_q;
    ether_d  = ether_q;
    nh_d     = nh_q;
    seo_d    = seo_q;
    ts_d     = ts_q;
    ext_d    = ext_q;
    src_hi_d = src_hi_q;
    src_lo_d = src_lo_q;
    dst_hi_d = dst_hi_q;
    dst_lo_d = dst_lo_q;
    ports_d  = ports_q;
    thl_d    = thl_q;
    err_d    = err_q;
    frag_d   = frag_q;
    udp_d    = udp_q;
    res_d    = res_q;
    out_valid_d = out_valid_q && !out_o.ready;

    off      = offset_q;
    b        = in_byte_q;
    rel      = off - ts_q;
    hl       = '0;
    enter    = 1'b0;
    en_type  = nh_q;
    en_start = '0;
    sum      = '0;
    caplen   = '0;
    after    = '0;
    st       = fhp_pkg::ST_OK;

    if (process) begin
      if (off == 16'hFFFF) begin
        // Frame too long: flag it unless an earlier fault stands
        if (err_q == fhp_pkg::ST_OK) begin
          err_d   = fhp_pkg::ST_OVERSIZE;
          phase_d = PH_ERROR;
        end
      end else begin
        case (phase_q)
          PH_ETH: begin
            if (off == 16'd12 || off == 16'd13) begin
              ether_d = {ether_q[7:0], b};
            end
            if (off == 16'd13) begin
              if (ether_d == fhp_pkg::ETH_IPV4) begin
                phase_d = PH_IPV4;
              end else if (ether_d == fhp_pkg::ETH_IPV6) begin
                phase_d = PH_IPV6;
              end else begin
                err_d   = fhp_pkg::ST_NOT_IP;
                phase_d = PH_ERROR;
              end
            end
          end
          PH_IPV4: begin
            if (off == 16'd14) begin
              hl = {2'b00, b[3:0], 2'b00};
              if (hl < 8'd20) begin
                hl = 8'd20;
              end
              ts_d = 16'd14 + {8'd0, hl};
            end else if (off == 16'd23) begin
              nh_d = b;
            end else if (off >= 16'd26 && off <= 16'd29) begin
              src_lo_d = {32'd0, src_lo_q[23:0], b};
            end else if (off >= 16'd30 && off <= 16'd33) begin
              dst_lo_d = {32'd0, dst_lo_q[23:0], b};
            end
            if (off >= 16'd33 && ({1'b0, off} + 17'd1) == {1'b0, ts_d}) begin
              phase_d = PH_TRANSPORT;
              if (nh_d == fhp_pkg::NH_TCP) begin
                thl_d = fhp_pkg::TCP_MIN_HLEN;
              end else if (nh_d == fhp_pkg::NH_UDP) begin
                thl_d = fhp_pkg::UDP_HLEN;
              end else begin
                thl_d = '0;
              end
            end
          end
          PH_IPV6: begin
            if (off == 16'd20) begin
              nh_d = b;
            end else if (off >= 16'd22 && off <= 16'd29) begin
              src_hi_d = {src_hi_q[55:0], b};
            end else if (off >= 16'd30 && off <= 16'd37) begin
              src_lo_d = {src_lo_q[55:0], b};
            end else if (off >= 16'd38 && off <= 16'd45) begin
              dst_hi_d = {dst_hi_q[55:0], b};
            end else if (off >= 16'd46 && off <= 16'd53) begin
              dst_lo_d = {dst_lo_q[55:0], b};
            end
            if (off == 16'd53) begin
              enter    = 1'b1;
              en_type  = nh_d;
              en_start = 16'd54;
            end
          end
          PH_EXT: begin
            if (rel == 16'd0) begin
              nh_d = b;
            end
            if (rel == 16'd1 && !frag_q) begin
              sum   = {1'b0, ts_q} + {6'd0, b, 3'b000} + 17'd8;
              seo_d = sum[16] ? 16'hFFFF : sum[15:0];
            end
            if ((frag_q || rel >= 16'd1) && ({1'b0, off} + 17'd1) == {1'b0, seo_d}) begin
              enter    = 1'b1;
              en_type  = nh_d;
              en_start = seo_d;
            end
          end
          PH_TRANSPORT: begin
            if (rel <= 16'd3) begin
              ports_d = {ports_q[23:0], b};
            end
            if (nh_q == fhp_pkg::NH_TCP && rel == 16'd12) begin
              hl    = {2'b00, b[7:4], 2'b00};
              thl_d = (hl < 8'd20) ? fhp_pkg::TCP_MIN_HLEN : hl[6:0];
            end else if (nh_q == fhp_pkg::NH_UDP && rel == 16'd4) begin
              udp_d = {b, 8'd0};
            end else if (nh_q == fhp_pkg::NH_UDP && rel == 16'd5) begin
              udp_d = {udp_q[15:8], b};
              if (udp_d == 16'd0 || udp_d > 16'd8) begin
                thl_d = fhp_pkg::UDP_HLEN;
              end else begin
                thl_d = udp_d[6:0];
              end
            end
          end
          default: begin
          end
        endcase

        // Open the next section: transport, extension header or fault
        if (enter) begin
          case (en_type)
            fhp_pkg::NH_TCP, fhp_pkg::NH_UDP: begin
              phase_d = PH_TRANSPORT;
              ts_d    = en_start;
              nh_d    = en_type;
              thl_d   = (en_type == fhp_pkg::NH_TCP) ? fhp_pkg::TCP_MIN_HLEN
                                                     : fhp_pkg::UDP_HLEN;
            end
            fhp_pkg::NH_HOP_BY_HOP, fhp_pkg::NH_ROUTING,
            fhp_pkg::NH_FRAGMENT, fhp_pkg::NH_DEST_OPT: begin
              if (ext_q >= MaxExt) begin
                err_d   = fhp_pkg::ST_TOO_MANY_EXT;
                phase_d = PH_ERROR;
              end else begin
                ext_d   = ext_q + 4'd1;
                ts_d    = en_start;
                frag_d  = (en_type == fhp_pkg::NH_FRAGMENT);
                sum     = {1'b0, en_start} + 17'd8;
                if (frag_d) begin
                  seo_d = sum[16] ? 16'hFFFF : sum[15:0];
                end else begin
                  seo_d = 16'hFFFF;
                end
                phase_d = PH_EXT;
              end
            end
            default: begin
              err_d   = fhp_pkg::ST_BAD_NH;
              phase_d = PH_ERROR;
            end
          endcase
        end
      end

      if (!in_last_q) begin
        // Advance the offset, saturating at the top
        if (off != 16'hFFFF) begin
          offset_d = off + 16'd1;
        end
      end else begin
        // Close the frame: decide the status and load the result
        caplen = {1'b0, off} + 17'd1;
        after  = caplen - {1'b0, ts_d};
        if (err_d != fhp_pkg::ST_OK) begin
          st = err_d;
        end else if (phase_d != PH_TRANSPORT) begin
          st = fhp_pkg::ST_TRUNC;
        end else if (after == 17'd0) begin
          st = fhp_pkg::ST_TRUNC;
        end else if (nh_d != fhp_pkg::NH_TCP && nh_d != fhp_pkg::NH_UDP) begin
          st = fhp_pkg::ST_BAD_TRANSPORT;
        end else if (after <= {10'd0, thl_d}) begin
          st = fhp_pkg::ST_TRUNC;
        end else if (nh_d == fhp_pkg::NH_UDP && after < 17'd6) begin
          st = fhp_pkg::ST_TRUNC;
        end else begin
          st = fhp_pkg::ST_OK;
        end

        res_d        = '0;
        res_d.status = st;
        if (st == fhp_pkg::ST_OK) begin
          res_d.is_ipv6       = (ether_d == fhp_pkg::ETH_IPV6);
          res_d.ip_proto      = nh_d;
          res_d.src_addr_high = src_hi_d;
          res_d.src_addr_low  = src_lo_d;
          res_d.dst_addr_high = dst_hi_d;
          res_d.dst_addr_low  = dst_lo_d;
          res_d.src_port      = ports_d[31:16];
          res_d.dst_port      = ports_d[15:0];
          res_d.payload_len   = 16'(after - {10'd0, thl_d});
        end
        out_valid_d = 1'b1;

        // Return to the start-of-frame state
        phase_d  = PH_ETH;
        offset_d = '0;
        ether_d  = '0;
        nh_d     = '0;
        seo_d    = '0;
        ts_d     = '0;
        ext_d    = '0;
        src_hi_d = '0;
        src_lo_d = '0;
        dst_hi_d = '0;
        dst_lo_d = '0;
        ports_d  = '0;
        thl_d    = '0;
        err_d    = fhp_pkg::ST_OK;
        frag_d   = 1'b0;
        udp_d    = '0;
      end
    end
  end

  // Hold the parse state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ETH;
      offset_q    <= '0;
      ether_q     <= '0;
      nh_q        <= '0;
      seo_q       <= '0;
      ts_q        <= '0;
      ext_q       <= '0;
      src_hi_q    <= '0;
      src_lo_q    <= '0;
      dst_hi_q    <= '0;
      dst_lo_q    <= '0;
      ports_q     <= '0;
      thl_q       <= '0;
      err_q       <= fhp_pkg::ST_OK;
      frag_q      <= 1'b0;
      udp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      offset_q    <= offset_d;
      ether_q     <= ether_d;
      nh_q        <= nh_d;
      seo_q       <= seo_d;
      ts_q        <= ts_d;
      ext_q       <= ext_d;
      src_hi_q    <= src_hi_d;
      src_lo_q    <= src_lo_d;
      dst_hi_q    <= dst_hi_d;
      dst_lo_q    <= dst_lo_d;
      ports_q     <= ports_d;
      thl_q       <= thl_d;
      err_q       <= err_d;
      frag_q      <= frag_d;
      udp_q       <= udp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Drive the result channel
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.is_ipv6       = res_q.is_ipv6;
  assign out_o.ip_proto      = res_q.ip_proto;
  assign out_o.src_addr_high = res_q.src_addr_high;
  assign out_o.src_addr_low  = res_q.src_addr_low;
  assign out_o.dst_addr_high = res_q.dst_addr_high;
  assign out_o.dst_addr_low  = res_q.dst_addr_low;
  assign out_o.src_port      = res_q.src_port;
  assign out_o.dst_port      = res_q.dst_port;
  assign out_o.payload_len   = res_q.payload_len;

  // A new result word follows only a processed last byte
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(process && in_last_q))
    else $error("result word without a last byte");

  // A good result carries TCP or UDP
  a_ok_transport: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == fhp_pkg::ST_OK) |->
      (res_q.ip_proto == fhp_pkg::NH_TCP || res_q.ip_proto == fhp_pkg::NH_UDP))
    else $error("ok status with a non TCP/UDP protocol");

  // A faulted result carries zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != fhp_pkg::ST_OK) |->
      (res_q.src_port == '0 && res_q.payload_len == '0 && res_q.ip_proto == '0))
    else $error("faulted result with nonzero fields");

  // The extension count stays within its bound
  a_ext_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_q <= MaxExt)
    else $error("extension count over bound");

endmodule
